FILE: sv/texture_bilinear_sampler_top_defines.svh
// Assertion macros for the port-level checker of the texture sampler.
`ifndef TEXTURE_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define TEXTURE_BILINEAR_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tbs_pkg.sv
// Shared types and constants of the texture bilinear sampler.
package tbs_pkg;

  localparam int unsigned COORD_W = 17;
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NCH     = 4;
  localparam int unsigned RES_W   = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = DIM_W + COORD_W;
  localparam int unsigned ROW_W   = 2 * DIM_W;
  localparam int unsigned WT_W    = 2 * FRAC_W + 1;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned NTAP    = 4;
  localparam int unsigned TAP_W   = 2;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned HALF    = 1 << (FRAC_W - 1);
  localparam int unsigned ONE     = 1 << FRAC_W;
  localparam int unsigned RND_POS = 24;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FETCH = 2'd1,
    OP_BLEND = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_PRESENT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    K_ZERO   = 2'd0,
    K_WRITE  = 2'd1,
    K_SAMPLE = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } bstate_t;

  typedef struct packed {
    logic [DIM_W-1:0]  lo;
    logic [DIM_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  typedef struct packed {
    kind_t                  kind;
    logic [NCH-1:0]         mask;
    logic [NCH*BYTE_W-1:0]  wdata;
    logic [NTAP*WT_W-1:0]   wts;
  } item_t;

  function automatic logic [NCH-1:0] chan_mask(input logic [CNT_W-1:0] cc);
    logic [NCH-1:0] m;
    unique case (cc)
      3'd0:    m = 4'b0000;
      3'd1:    m = 4'b0001;
      3'd2:    m = 4'b0011;
      3'd3:    m = 4'b0111;
      default: m = 4'b1111;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/tbs_front.sv
// Front end: accepts transactions, scales coordinates, builds taps and weights.
module tbs_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned AW         = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_push,
  output logic                                       in_full,
  input  logic [1:0]                                 in_opcode,
  input  logic [tbs_pkg::COORD_W-1:0]                in_coord_u,
  input  logic [tbs_pkg::COORD_W-1:0]                in_coord_v,
  input  logic [tbs_pkg::NCH*tbs_pkg::BYTE_W-1:0]    in_wdata,
  input  logic [tbs_pkg::DIM_W-1:0]                  cfg_width,
  input  logic [tbs_pkg::DIM_W-1:0]                  cfg_height,
  input  logic [tbs_pkg::CNT_W-1:0]                  cfg_channels,
  input  logic                                       cfg_present,
  output logic                                       q_push,
  input  logic                                       q_full,
  output tbs_pkg::item_t                             q_item,
  output logic [tbs_pkg::NTAP*AW-1:0]                q_addr
);

  localparam int unsigned DW = tbs_pkg::DIM_W;
  localparam int unsigned PW = tbs_pkg::PROD_W;
  localparam int unsigned FW = tbs_pkg::FRAC_W;
  localparam int unsigned NW = PW - FW + 1;
  localparam int unsigned RW = tbs_pkg::ROW_W;
  localparam int unsigned WW = tbs_pkg::WT_W;
  localparam int unsigned MW = 2 * (FW + 1);

  function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v, input int unsigned maxv);
    logic [DW-1:0] r;
    priority if (v == '0) r = DW'(1);
    else if (32'(v) > maxv) r = DW'(maxv);
    else r = v;
    return r;
  endfunction

  function automatic tbs_pkg::axis_t map_axis(input logic [PW-1:0] p, input logic [DW-1:0] dim,
                                              input logic near);
    logic [DW-1:0]  last;
    logic [PW:0]    rnd;
    logic [NW-1:0]  pn;
    logic [PW-1:0]  lim;
    logic [PW-1:0]  pc;
    tbs_pkg::axis_t a;
    last = dim - DW'(1);
    rnd  = {1'b0, p} + (PW+1)'(tbs_pkg::HALF);
    pn   = rnd[PW:FW];
    lim  = PW'({last, {FW{1'b0}}});
    pc   = (p > lim) ? lim : p;
    if (near) begin
      a.lo   = (pn > NW'(last)) ? last : DW'(pn);
      a.hi   = a.lo;
      a.frac = '0;
    end else begin
      a.lo   = pc[FW +: DW];
      a.hi   = (a.lo == last) ? a.lo : a.lo + DW'(1);
      a.frac = pc[FW-1:0];
    end
    return a;
  endfunction

  logic [DW-1:0] w_eff, h_eff;
  logic          accept;

  logic                                    s1_vld_r, s1_vld_nxt;
  tbs_pkg::kind_t                          s1_kind_r, s1_kind_nxt;
  logic                                    s1_near_r, s1_near_nxt;
  logic [PW-1:0]                           s1_pu_r, s1_pu_nxt;
  logic [PW-1:0]                           s1_pv_r, s1_pv_nxt;
  logic [tbs_pkg::NCH-1:0]                 s1_mask_r, s1_mask_nxt;
  logic [tbs_pkg::NCH*tbs_pkg::BYTE_W-1:0] s1_wdata_r, s1_wdata_nxt;

  tbs_pkg::axis_t ax, ay;
  logic [FW:0]    ifx, ify;
  logic [MW-1:0]  p00, p10, p01, p11;
  logic [RW-1:0]  r0, r1;
  logic [RW-1:0]  a00, a10, a01, a11;

  assign w_eff   = eff_dim(cfg_width, MAX_WIDTH);
  assign h_eff   = eff_dim(cfg_height, MAX_HEIGHT);
  assign in_full = s1_vld_r & q_full;
  assign accept  = in_push & ~in_full;
  assign q_push  = s1_vld_r & ~q_full;

  always_comb begin
    s1_vld_nxt   = accept | (s1_vld_r & q_full);
    s1_kind_nxt  = s1_kind_r;
    s1_near_nxt  = s1_near_r;
    s1_pu_nxt    = s1_pu_r;
    s1_pv_nxt    = s1_pv_r;
    s1_mask_nxt  = s1_mask_r;
    s1_wdata_nxt = s1_wdata_r;
    if (accept) begin
      priority if (!cfg_present || in_opcode == tbs_pkg::OP_NONE) s1_kind_nxt = tbs_pkg::K_ZERO;
      else if (in_opcode == tbs_pkg::OP_WRITE) s1_kind_nxt = tbs_pkg::K_WRITE;
      else s1_kind_nxt = tbs_pkg::K_SAMPLE;
      s1_near_nxt  = (in_opcode != tbs_pkg::OP_BLEND);
      s1_pu_nxt    = PW'(w_eff) * PW'(in_coord_u);
      s1_pv_nxt    = PW'(h_eff) * PW'(in_coord_v);
      s1_mask_nxt  = tbs_pkg::chan_mask(cfg_channels);
      s1_wdata_nxt = in_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    s1_kind_r  <= s1_kind_nxt;
    s1_near_r  <= s1_near_nxt;
    s1_pu_r    <= s1_pu_nxt;
    s1_pv_r    <= s1_pv_nxt;
    s1_mask_r  <= s1_mask_nxt;
    s1_wdata_r <= s1_wdata_nxt;
  end

  always_comb begin
    ax  = map_axis(s1_pu_r, w_eff, s1_near_r);
    ay  = map_axis(s1_pv_r, h_eff, s1_near_r);
    ifx = (FW+1)'(tbs_pkg::ONE) - {1'b0, ax.frac};
    ify = (FW+1)'(tbs_pkg::ONE) - {1'b0, ay.frac};
    p00 = ifx * ify;
    p10 = {1'b0, ax.frac} * ify;
    p01 = ifx * {1'b0, ay.frac};
    p11 = {1'b0, ax.frac} * {1'b0, ay.frac};
    r0  = ay.lo * w_eff;
    r1  = ay.hi * w_eff;
    a00 = r0 + RW'(ax.lo);
    a10 = r0 + RW'(ax.hi);
    a01 = r1 + RW'(ax.lo);
    a11 = r1 + RW'(ax.hi);
  end

  assign q_item.kind  = s1_kind_r;
  assign q_item.mask  = s1_mask_r;
  assign q_item.wdata = s1_wdata_r;
  assign q_item.wts   = {WW'(p11), WW'(p01), WW'(p10), WW'(p00)};
  assign q_addr       = {AW'(a11), AW'(a01), AW'(a10), AW'(a00)};

endmodule

FILE: sv/tbs_queue.sv
// Short register queue between the front end and the back end.
module tbs_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int unsigned DEPTH = tbs_pkg::Q_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     ent_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (32'(cnt_r) == DEPTH);
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = ent_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? bump(wp_r) : wp_r;
    rp_nxt  = do_pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r;
    priority if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
    else cnt_nxt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wp_r] <= din;
    end
  end

endmodule

FILE: sv/tbs_back.sv
// Back end: texel store, four-tap read sequencer, weighted accumulate, result register.
module tbs_back #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_empty,
  output logic                                    q_pop,
  input  tbs_pkg::item_t                          q_item,
  input  logic [tbs_pkg::NTAP*AW-1:0]             q_addr,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [tbs_pkg::NCH*tbs_pkg::RES_W-1:0]  out_data
);

  localparam int unsigned NCH = tbs_pkg::NCH;
  localparam int unsigned BW  = tbs_pkg::BYTE_W;
  localparam int unsigned WW  = tbs_pkg::WT_W;
  localparam int unsigned AC  = tbs_pkg::ACC_W;
  localparam int unsigned RSW = tbs_pkg::RES_W;
  localparam int unsigned TW  = tbs_pkg::TAP_W;
  localparam int unsigned DTW = NCH * BW;

  logic [DTW-1:0] mem [DEPTH];

  tbs_pkg::bstate_t state_r, state_nxt;

  logic [TW:0]                   iss_r, iss_nxt;
  logic                          rd_vld_r;
  logic [TW-1:0]                 rd_k_r;
  logic [DTW-1:0]                rd_data_r;
  logic                          mul_vld_r;
  logic [AC-1:0]                 mul_r [NCH];
  logic [AC-1:0]                 acc_r [NCH];
  logic [TW-1:0]                 acc_cnt_r;
  logic [tbs_pkg::NTAP*AW-1:0]   wk_addr_r;
  logic [tbs_pkg::NTAP*WW-1:0]   wk_wts_r;
  logic [NCH-1:0]                wk_mask_r;
  logic                          out_vld_r, out_vld_nxt;
  logic [NCH*RSW-1:0]            out_data_r, out_data_nxt;

  logic           out_take, out_free, start, last;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr;
  logic [WW-1:0]  wt_sel;
  logic [BW+WW-1:0] prod [NCH];
  logic [AC-1:0]  sum [NCH];
  logic [AC-1:0]  rnd [NCH];
  logic [NCH*RSW-1:0] res;

  assign out_take  = out_pop & out_vld_r;
  assign out_free  = ~out_vld_r | out_take;
  assign start     = (state_r == tbs_pkg::ST_IDLE) & ~q_empty & out_free;
  assign last      = mul_vld_r & (acc_cnt_r == TW'(tbs_pkg::NTAP - 1));
  assign out_empty = ~out_vld_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbs_pkg::ST_IDLE: begin
        if (start && q_item.kind == tbs_pkg::K_SAMPLE) state_nxt = tbs_pkg::ST_RUN;
      end
      tbs_pkg::ST_RUN: begin
        if (last) state_nxt = tbs_pkg::ST_IDLE;
      end
      default: state_nxt = tbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = start;
    wr_en   = start & (q_item.kind == tbs_pkg::K_WRITE);
    rd_en   = (state_r == tbs_pkg::ST_RUN) & ~iss_r[TW];
    rd_addr = wk_addr_r[iss_r[TW-1:0]*AW +: AW];
    iss_nxt = start ? '0 : (rd_en ? iss_r + (TW+1)'(1) : iss_r);
    wt_sel  = wk_wts_r[rd_k_r*WW +: WW];
    for (int c = 0; c < NCH; c++) begin
      prod[c] = rd_data_r[c*BW +: BW] * wt_sel;
      sum[c]  = acc_r[c] + mul_r[c];
      rnd[c]  = sum[c] + AC'(1 << (tbs_pkg::RND_POS - 1));
      res[c*RSW +: RSW] = wk_mask_r[c] ? rnd[c][tbs_pkg::RND_POS +: RSW] : '0;
    end
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    priority if (last) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = res;
    end else if (start && q_item.kind != tbs_pkg::K_SAMPLE) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = '0;
    end else if (out_take) begin
      out_vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int c = 0; c < NCH; c++) begin
        if (q_item.mask[c]) mem[q_addr[AW-1:0]][c*BW +: BW] <= q_item.wdata[c*BW +: BW];
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tbs_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      iss_r     <= '0;
      acc_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      rd_vld_r  <= rd_en;
      mul_vld_r <= rd_vld_r;
      iss_r     <= iss_nxt;
      if (start) acc_cnt_r <= '0;
      else if (mul_vld_r) acc_cnt_r <= acc_cnt_r + TW'(1);
    end
    out_data_r <= out_data_nxt;
    rd_k_r     <= iss_r[TW-1:0];
    if (start) begin
      wk_addr_r <= q_addr;
      wk_wts_r  <= q_item.wts;
      wk_mask_r <= q_item.mask;
    end
    for (int c = 0; c < NCH; c++) begin
      if (rd_vld_r) mul_r[c] <= AC'(prod[c]);
      if (start) acc_r[c] <= '0;
      else if (mul_vld_r) acc_r[c] <= sum[c];
    end
  end

endmodule

FILE: sv/texture_bilinear_sampler_top.sv
// Top level of the texture bilinear sampler.
//
// Input queue port: push/full carries opcode, u, v in Q1.16 and four write bytes.
// Result queue port: empty/pop carries four channels in Q8.8, one per transaction.
// Opcode 0 writes the nearest texel, 1 fetches it, 2 blends four neighbors.
// Config port: cfg_wr_en/cfg_index/cfg_data write width, height, channels,
// store-present; write only while the block is idle.
// The front end scales coordinates and forms four addresses and weights,
// then hands them through a two-entry queue to the back end.
// Back end: one single-port texel store; fetch and blend read four taps, one per
// cycle, then multiply and accumulate before the next transaction is taken.
// Writes and zero results go straight from the queue to the result register.
// On the way to a result, every transaction passes the front-end register and queue.
// Reset empties all queues and clears the config to 1x1, 4 channels, no store.
// The texel store is not cleared; reading an unwritten texel gives arbitrary data.
// With the result port stalled, the front end and queue keep taking transactions
// until full, then full is held.
module texture_bilinear_sampler_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_index,
  input  logic [tbs_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [1:0]                        in_opcode,
  input  logic [tbs_pkg::COORD_W-1:0]       in_coord_u,
  input  logic [tbs_pkg::COORD_W-1:0]       in_coord_v,
  input  logic [tbs_pkg::BYTE_W-1:0]        in_wr_ch0,
  input  logic [tbs_pkg::BYTE_W-1:0]        in_wr_ch1,
  input  logic [tbs_pkg::BYTE_W-1:0]        in_wr_ch2,
  input  logic [tbs_pkg::BYTE_W-1:0]        in_wr_ch3,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [tbs_pkg::RES_W-1:0]         out_ch0,
  output logic [tbs_pkg::RES_W-1:0]         out_ch1,
  output logic [tbs_pkg::RES_W-1:0]         out_ch2,
  output logic [tbs_pkg::RES_W-1:0]         out_ch3
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = $bits(tbs_pkg::item_t);
  localparam int unsigned QW    = IW + tbs_pkg::NTAP * AW;
  localparam int unsigned RSW   = tbs_pkg::RES_W;

  logic [tbs_pkg::DIM_W-1:0] cfg_width_r, cfg_width_nxt;
  logic [tbs_pkg::DIM_W-1:0] cfg_height_r, cfg_height_nxt;
  logic [tbs_pkg::CNT_W-1:0] cfg_chan_r, cfg_chan_nxt;
  logic                      cfg_present_r, cfg_present_nxt;

  logic                         enq_push, enq_full, deq_pop, deq_empty;
  tbs_pkg::item_t               enq_item, deq_item;
  logic [tbs_pkg::NTAP*AW-1:0]  enq_addr, deq_addr;
  logic [QW-1:0]                deq_data;
  logic [tbs_pkg::NCH*RSW-1:0]  res_data;

  always_comb begin
    cfg_width_nxt   = cfg_width_r;
    cfg_height_nxt  = cfg_height_r;
    cfg_chan_nxt    = cfg_chan_r;
    cfg_present_nxt = cfg_present_r;
    if (cfg_wr_en) begin
      unique case (tbs_pkg::cfg_idx_t'(cfg_index))
        tbs_pkg::CFG_WIDTH:    cfg_width_nxt   = cfg_data;
        tbs_pkg::CFG_HEIGHT:   cfg_height_nxt  = cfg_data;
        tbs_pkg::CFG_CHANNELS: cfg_chan_nxt    = cfg_data[tbs_pkg::CNT_W-1:0];
        tbs_pkg::CFG_PRESENT:  cfg_present_nxt = cfg_data[0];
        default:               cfg_present_nxt = cfg_present_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r   <= tbs_pkg::DIM_W'(1);
      cfg_height_r  <= tbs_pkg::DIM_W'(1);
      cfg_chan_r    <= tbs_pkg::CNT_W'(4);
      cfg_present_r <= 1'b0;
    end else begin
      cfg_width_r   <= cfg_width_nxt;
      cfg_height_r  <= cfg_height_nxt;
      cfg_chan_r    <= cfg_chan_nxt;
      cfg_present_r <= cfg_present_nxt;
    end
  end

  tbs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_opcode    (in_opcode),
    .in_coord_u   (in_coord_u),
    .in_coord_v   (in_coord_v),
    .in_wdata     ({in_wr_ch3, in_wr_ch2, in_wr_ch1, in_wr_ch0}),
    .cfg_width    (cfg_width_r),
    .cfg_height   (cfg_height_r),
    .cfg_channels (cfg_chan_r),
    .cfg_present  (cfg_present_r),
    .q_push       (enq_push),
    .q_full       (enq_full),
    .q_item       (enq_item),
    .q_addr       (enq_addr)
  );

  tbs_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (enq_push),
    .full  (enq_full),
    .din   ({enq_addr, enq_item}),
    .pop   (deq_pop),
    .empty (deq_empty),
    .dout  (deq_data)
  );

  assign deq_item = tbs_pkg::item_t'(deq_data[IW-1:0]);
  assign deq_addr = deq_data[QW-1:IW];

  tbs_back #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (deq_empty),
    .q_pop     (deq_pop),
    .q_item    (deq_item),
    .q_addr    (deq_addr),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (res_data)
  );

  assign out_ch0 = res_data[0*RSW +: RSW];
  assign out_ch1 = res_data[1*RSW +: RSW];
  assign out_ch2 = res_data[2*RSW +: RSW];
  assign out_ch3 = res_data[3*RSW +: RSW];

endmodule

FILE: sv/tbs_port_chk.sv
// Port-level checker for the texture sampler, bound to the top level.
`include "texture_bilinear_sampler_top_defines.svh"

module tbs_port_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        cfg_wr_en,
  input logic [1:0]                  cfg_index,
  input logic [tbs_pkg::DIM_W-1:0]   cfg_data,
  input logic                        in_push,
  input logic                        in_full,
  input logic [1:0]                  in_opcode,
  input logic [tbs_pkg::COORD_W-1:0] in_coord_u,
  input logic [tbs_pkg::COORD_W-1:0] in_coord_v,
  input logic [tbs_pkg::BYTE_W-1:0]  in_wr_ch0,
  input logic [tbs_pkg::BYTE_W-1:0]  in_wr_ch1,
  input logic [tbs_pkg::BYTE_W-1:0]  in_wr_ch2,
  input logic [tbs_pkg::BYTE_W-1:0]  in_wr_ch3,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [tbs_pkg::RES_W-1:0]   out_ch0,
  input logic [tbs_pkg::RES_W-1:0]   out_ch1,
  input logic [tbs_pkg::RES_W-1:0]   out_ch2,
  input logic [tbs_pkg::RES_W-1:0]   out_ch3
);

  logic [3:0] pend_r, pend_nxt;
  logic       acc_in, acc_out;

  assign acc_in  = in_push & ~in_full;
  assign acc_out = out_pop & ~out_empty;

  always_comb begin
    pend_nxt = pend_r;
    priority if (acc_in && !acc_out) pend_nxt = pend_r + 4'd1;
    else if (acc_out && !acc_in) pend_nxt = pend_r - 4'd1;
    else pend_nxt = pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `TBS_ASSERT_NOW(a_no_phantom, clk, rst_n, !out_empty, pend_r != 4'd0, "result without transaction")
  `TBS_ASSERT_NOW(a_full_busy, clk, rst_n, in_full, pend_r != 4'd0, "full while nothing pending")
  `TBS_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_ch0) && $stable(out_ch1) && $stable(out_ch2) && $stable(out_ch3), "stalled result changed")

endmodule

bind texture_bilinear_sampler_top tbs_port_chk u_port_chk (.*);

FILE: dv/texture_bilinear_sampler_checker.sv
// Checker for the texture sampler: predicts every result transaction and compares it.
module texture_bilinear_sampler_checker
  import tbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [1:0]         in_opcode,
  input  logic [COORD_W-1:0] in_coord_u,
  input  logic [COORD_W-1:0] in_coord_v,
  input  logic [BYTE_W-1:0]  in_wr_ch0,
  input  logic [BYTE_W-1:0]  in_wr_ch1,
  input  logic [BYTE_W-1:0]  in_wr_ch2,
  input  logic [BYTE_W-1:0]  in_wr_ch3,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [RES_W-1:0]   out_ch0,
  input  logic [RES_W-1:0]   out_ch1,
  input  logic [RES_W-1:0]   out_ch2,
  input  logic [RES_W-1:0]   out_ch3,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [3:0][15:0] color_t;

  logic [31:0] texels [65536];
  logic [8:0]  tex_w;
  logic [8:0]  tex_h;
  logic [2:0]  chan_cnt;
  logic        present;
  color_t      pending_colors [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [8:0] eff_size(input logic [8:0] raw);
    if (raw == 9'd0) return 9'd1;
    return (raw > 9'd256) ? 9'd256 : raw;
  endfunction

  function automatic logic [8:0] nearest_texel(input logic [8:0] size, input logic [16:0] coord);
    logic [26:0] p;
    p = size * coord + 27'd32768;
    p = p >> 16;
    return (p > size - 9'd1) ? size - 9'd1 : p[8:0];
  endfunction

  function automatic logic [7:0] texel_byte(input logic [8:0] x, input logic [8:0] y,
                                            input logic [8:0] w, input int c);
    logic [15:0] a;
    a = y * w + x;
    return texels[a][8*c +: 8];
  endfunction

  function automatic color_t sample_texels(input op_t op, input logic [16:0] u,
                                           input logic [16:0] v, input logic [3:0][7:0] wb);
    color_t      res;
    logic [8:0]  w, h, x0, y0, x1, y1;
    logic [2:0]  cc;
    logic [15:0] a;
    logic [25:0] px, py;
    logic [16:0] fx, fy;
    logic [32:0] w00, w10, w01, w11;
    logic [47:0] acc;
    res = '0;
    w   = eff_size(tex_w);
    h   = eff_size(tex_h);
    cc  = (chan_cnt > 3'd4) ? 3'd4 : chan_cnt;
    if (!present || op == OP_NONE) return res;
    if (op != OP_BLEND) begin
      x0 = nearest_texel(w, u);
      y0 = nearest_texel(h, v);
      a  = y0 * w + x0;
      for (int c = 0; c < cc; c++) begin
        if (op == OP_WRITE) texels[a][8*c +: 8] = wb[c];
        else res[c] = {texels[a][8*c +: 8], 8'h00};
      end
      return res;
    end
    px = w * u;
    py = h * v;
    if (px > {w - 9'd1, 16'h0000}) px = {w - 9'd1, 16'h0000};
    if (py > {h - 9'd1, 16'h0000}) py = {h - 9'd1, 16'h0000};
    x0  = px[24:16];
    y0  = py[24:16];
    fx  = {1'b0, px[15:0]};
    fy  = {1'b0, py[15:0]};
    x1  = (x0 + 9'd1 < w) ? x0 + 9'd1 : w - 9'd1;
    y1  = (y0 + 9'd1 < h) ? y0 + 9'd1 : h - 9'd1;
    w00 = (17'h10000 - fx) * (17'h10000 - fy);
    w10 = fx * (17'h10000 - fy);
    w01 = (17'h10000 - fx) * fy;
    w11 = fx * fy;
    for (int c = 0; c < cc; c++) begin
      acc = texel_byte(x0, y0, w, c) * w00 + texel_byte(x1, y0, w, c) * w10
          + texel_byte(x0, y1, w, c) * w01 + texel_byte(x1, y1, w, c) * w11
          + 48'h80_0000;
      res[c] = acc[39:24];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    color_t got, want;
    if (!rst_n) begin
      tex_w    = 9'd1;
      tex_h    = 9'd1;
      chan_cnt = 3'd4;
      present  = 1'b0;
      pending_colors.delete();
    end else begin
      if (out_pop && !out_empty) begin
        got = {out_ch3, out_ch2, out_ch1, out_ch0};
        if (pending_colors.size() == 0) begin
          report($sformatf("result %h with no transaction pending", got));
        end else begin
          want = pending_colors.pop_front();
          for (int c = 0; c < 4; c++)
            if (got[c] !== want[c])
              report($sformatf("out_ch%0d got %h expected %h", c, got[c], want[c]));
        end
      end
      if (in_push && !in_full)
        pending_colors.push_back(sample_texels(op_t'(in_opcode), in_coord_u, in_coord_v,
                                               {in_wr_ch3, in_wr_ch2, in_wr_ch1, in_wr_ch0}));
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:    tex_w    = cfg_data;
          CFG_HEIGHT:   tex_h    = cfg_data;
          CFG_CHANNELS: chan_cnt = cfg_data[2:0];
          CFG_PRESENT:  present  = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding <= pending_colors.size();
  end

endmodule

FILE: dv/texture_bilinear_sampler_top_test.sv
// Testbench top for the texture sampler: stimulus, flow control and verdict.
module texture_bilinear_sampler_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tbs_pkg::*;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_wr_en  = 1'b0;
  logic [1:0]          cfg_index  = 2'd0;
  logic [DIM_W-1:0]    cfg_data   = '0;
  logic                in_push    = 1'b0;
  logic [1:0]          in_opcode  = 2'd0;
  logic [COORD_W-1:0]  in_coord_u = '0;
  logic [COORD_W-1:0]  in_coord_v = '0;
  logic [BYTE_W-1:0]   in_wr_ch0  = '0;
  logic [BYTE_W-1:0]   in_wr_ch1  = '0;
  logic [BYTE_W-1:0]   in_wr_ch2  = '0;
  logic [BYTE_W-1:0]   in_wr_ch3  = '0;
  logic                out_pop    = 1'b0;
  logic                in_full;
  logic                out_empty;
  logic [RES_W-1:0]    out_ch0, out_ch1, out_ch2, out_ch3;
  int                  fail_count;
  int                  outstanding;

  // texel bytes known to hold written data, per store word
  logic [3:0]  texel_ok [65536];
  int unsigned tex_w, tex_h, eff_ch;
  bit          present;
  int unsigned win_x, win_y, win_sw, win_sh;
  int          burst_left;
  bit          hold_req;

  always #5 clk = ~clk;

  texture_bilinear_sampler_top dut (.*);
  texture_bilinear_sampler_checker chk (.*);

  function automatic int unsigned clamp_size(input int unsigned raw);
    if (raw == 0) return 1;
    return (raw > 256) ? 256 : raw;
  endfunction

  function automatic void texel_taps(input op_t op, input int unsigned u, input int unsigned v,
                                     output int unsigned taps [4]);
    int unsigned px, py, x0, y0, x1, y1;
    if (op != OP_BLEND) begin
      x0 = (tex_w * u + 32768) >> 16;
      y0 = (tex_h * v + 32768) >> 16;
      if (x0 > tex_w - 1) x0 = tex_w - 1;
      if (y0 > tex_h - 1) y0 = tex_h - 1;
      x1 = x0;
      y1 = y0;
    end else begin
      px = tex_w * u;
      py = tex_h * v;
      if (px > (tex_w - 1) << 16) px = (tex_w - 1) << 16;
      if (py > (tex_h - 1) << 16) py = (tex_h - 1) << 16;
      x0 = px >> 16;
      y0 = py >> 16;
      x1 = (x0 + 1 < tex_w) ? x0 + 1 : tex_w - 1;
      y1 = (y0 + 1 < tex_h) ? y0 + 1 : tex_h - 1;
    end
    taps = '{y0 * tex_w + x0, y0 * tex_w + x1, y1 * tex_w + x0, y1 * tex_w + x1};
  endfunction

  // a read may only touch texel bytes that were written
  function automatic bit taps_written(input op_t op, input int unsigned u, input int unsigned v);
    int unsigned taps [4];
    logic [3:0]  need;
    if (!present || eff_ch == 0 || op == OP_WRITE || op == OP_NONE) return 1'b1;
    need = 4'hF >> (4 - eff_ch);
    texel_taps(op, u, v, taps);
    foreach (taps[i])
      if ((texel_ok[taps[i]] & need) != need) return 1'b0;
    return 1'b1;
  endfunction

  task automatic push_texel_op(input op_t op, input int unsigned u, input int unsigned v,
                               input logic [31:0] bytes);
    int unsigned taps [4];
    if (op == OP_WRITE && present && eff_ch != 0) begin
      texel_taps(op, u, v, taps);
      texel_ok[taps[0]] |= 4'hF >> (4 - eff_ch);
    end
    in_opcode  <= op;
    in_coord_u <= u[16:0];
    in_coord_v <= v[16:0];
    in_wr_ch0  <= bytes[7:0];
    in_wr_ch1  <= bytes[15:8];
    in_wr_ch2  <= bytes[23:16];
    in_wr_ch3  <= bytes[31:24];
    in_push    <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic idle(input int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [8:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_texture(input int unsigned w, input int unsigned h,
                             input int unsigned cc, input bit pres);
    wait_drained();
    cfg_write(CFG_WIDTH, w[8:0]);
    cfg_write(CFG_HEIGHT, h[8:0]);
    cfg_write(CFG_CHANNELS, cc[8:0]);
    cfg_write(CFG_PRESENT, {8'd0, pres});
    tex_w   = clamp_size(w);
    tex_h   = clamp_size(h);
    eff_ch  = (cc > 4) ? 4 : cc;
    present = pres;
  endtask

  // mostly inside the active window, now and then anywhere up to the field limit
  function automatic int unsigned pick_coord(input int unsigned size, input int unsigned origin,
                                             input int unsigned span);
    int unsigned lo, hi;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 131071);
    lo = origin << 16;
    hi = (origin + span == size) ? size << 16 : ((origin + span - 1) << 16) - 1;
    return ($urandom_range(hi, lo) + size - 1) / size;
  endfunction

  function automatic int unsigned pick_origin(input int unsigned size, input int unsigned span);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return size - span;
      default: return $urandom_range(0, size - span);
    endcase
  endfunction

  task automatic random_texel_op();
    op_t         op;
    int unsigned u, v, pick, tries;
    pick = $urandom_range(0, 99);
    op = (pick < 35) ? OP_WRITE : (pick < 60) ? OP_FETCH : (pick < 95) ? OP_BLEND : OP_NONE;
    tries = 0;
    do begin
      u = pick_coord(tex_w, win_x, win_sw);
      v = pick_coord(tex_h, win_y, win_sh);
      tries++;
    end while (!taps_written(op, u, v) && tries < 8);
    if (!taps_written(op, u, v)) op = OP_WRITE;
    push_texel_op(op, u, v, $urandom());
    if (burst_left <= 0) begin
      if ($urandom_range(0, 9) < 7) idle($urandom_range(1, 8));
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned cc,
                           input bit pres, input int n);
    set_texture(w, h, cc, pres);
    win_sw = (tex_w <= 8) ? tex_w : 4;
    win_sh = (tex_h <= 8) ? tex_h : 4;
    win_x  = pick_origin(tex_w, win_sw);
    win_y  = pick_origin(tex_h, win_sh);
    for (int unsigned y = win_y; y < win_y + win_sh; y++)
      for (int unsigned x = win_x; x < win_x + win_sw; x++)
        push_texel_op(OP_WRITE, (x * 65536 + tex_w - 1) / tex_w,
                      (y * 65536 + tex_h - 1) / tex_h, $urandom());
    repeat (n) random_texel_op();
  endtask

  // receiver: random pop rate per stretch, one long hold-off on request
  initial begin
    int unsigned pop_pct, mode_left;
    mode_left = 0;
    pop_pct   = 100;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0:       pop_pct = 100;
            1:       pop_pct = 70;
            2:       pop_pct = 35;
            default: pop_pct = 10;
          endcase
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        out_pop <= ($urandom_range(0, 99) < pop_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    foreach (texel_ok[i]) texel_ok[i] = 4'h0;
    tex_w      = 1;
    tex_h      = 1;
    eff_ch     = 4;
    present    = 1'b0;
    burst_left = 0;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no store after reset: everything reads zero, writes are dropped
    push_texel_op(OP_WRITE, 0, 0, 32'hFFFF_FFFF);
    push_texel_op(OP_FETCH, 131071, 131071, 32'h0);
    push_texel_op(OP_BLEND, 65536, 65536, 32'h0);
    push_texel_op(OP_NONE, 131071, 0, 32'hFFFF_FFFF);

    // single texel, coordinates at and past one
    set_texture(1, 1, 4, 1'b1);
    push_texel_op(OP_WRITE, 0, 0, 32'hFFFF_FFFF);
    push_texel_op(OP_FETCH, 131071, 131071, 32'h0);
    push_texel_op(OP_BLEND, 65536, 32768, 32'h0);
    push_texel_op(OP_WRITE, 131071, 65536, 32'h0);
    push_texel_op(OP_FETCH, 0, 0, 32'hFFFF_FFFF);
    push_texel_op(OP_WRITE, 32768, 1, 32'hC33C_5AA5);
    push_texel_op(OP_BLEND, 0, 131071, 32'h0);
    push_texel_op(OP_NONE, 0, 0, 32'h0);

    // 2x2: half-texel blends and the rounding boundary
    run_phase(2, 2, 4, 1'b1, 0);
    push_texel_op(OP_BLEND, 16384, 49152, 32'h0);
    push_texel_op(OP_BLEND, 32768, 32768, 32'h0);
    push_texel_op(OP_FETCH, 16383, 16384, 32'h0);
    push_texel_op(OP_BLEND, 65535, 1, 32'h0);
    repeat (40) random_texel_op();

    run_phase(256, 256, 4, 1'b1, 10);
    hold_req = 1'b1;
    repeat (40) random_texel_op();
    run_phase(256, 1, 3, 1'b1, 45);
    run_phase(1, 256, 2, 1'b1, 45);
    run_phase(0, 511, 1, 1'b1, 45);
    run_phase(7, 5, 6, 1'b1, 45);
    run_phase(300, 3, 0, 1'b1, 40);
    run_phase(5, 3, 4, 1'b0, 35);
    run_phase(100, 37, 4, 1'b1, 25);
    wait_drained();
    repeat (25) random_texel_op();
    run_phase(3, 8, 1, 1'b1, 45);
    run_phase(16, 16, 4, 1'b1, 45);
    run_phase(256, 256, 4, 1'b1, 45);
    wait_drained();

    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS texture_bilinear_sampler_top");
    end else begin
      $display("FAIL texture_bilinear_sampler_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL texture_bilinear_sampler_top");
    $finish;
  end

endmodule
